FILE: sv/hgc_pkg.sv
// Shared constants, types and tables for the haversine geofence check.
package hgc_pkg;
    localparam int ANGLE_FRAC_BITS = 20;
    localparam int DIST_FRAC_BITS  = 4;

    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int DEG_W   = 29;
    localparam int DIST_W  = 29;
    localparam int MAXD_W  = 16;
    localparam int BANG_W  = 32;
    localparam int CW      = 34;
    localparam int HW      = 36;
    localparam int Q30_W   = 31;
    localparam int LANES   = 4;
    localparam int SQ_LANES = 2;
    localparam int CORDIC_STEPS = 28;
    localparam int SQRT_STEPS   = 31;

    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;
    localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [31:0] PI_Q29 = 32'h6487_ED51;
    localparam logic [22:0] EARTH_R = 23'd6371000;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;
    localparam logic [MAXD_W-1:0] MAX_DIST_RST = 16'd30;

    localparam logic [1:0] REG_REF_LAT  = 2'd0;
    localparam logic [1:0] REG_REF_LON  = 2'd1;
    localparam logic [1:0] REG_MAX_DIST = 2'd2;

    typedef logic signed [CW-1:0] t_cw;

    function automatic t_cw atan_c(input int idx);
        t_cw v;
        case (idx)
            0:  v = 34'sh0_2000_0000;
            1:  v = 34'sh0_12E4_051E;
            2:  v = 34'sh0_09FB_385B;
            3:  v = 34'sh0_0511_11D4;
            4:  v = 34'sh0_028B_0D43;
            5:  v = 34'sh0_0145_D7E1;
            6:  v = 34'sh0_00A2_F61E;
            7:  v = 34'sh0_0051_7C55;
            8:  v = 34'sh0_0028_BE53;
            9:  v = 34'sh0_0014_5F2F;
            10: v = 34'sh0_000A_2F98;
            11: v = 34'sh0_0005_17CC;
            12: v = 34'sh0_0002_8BE6;
            13: v = 34'sh0_0001_45F3;
            14: v = 34'sh0_0000_A2FA;
            15: v = 34'sh0_0000_517D;
            16: v = 34'sh0_0000_28BE;
            17: v = 34'sh0_0000_145F;
            18: v = 34'sh0_0000_0A30;
            19: v = 34'sh0_0000_0518;
            20: v = 34'sh0_0000_028C;
            21: v = 34'sh0_0000_0146;
            22: v = 34'sh0_0000_00A3;
            23: v = 34'sh0_0000_0051;
            24: v = 34'sh0_0000_0029;
            25: v = 34'sh0_0000_0014;
            26: v = 34'sh0_0000_000A;
            27: v = 34'sh0_0000_0005;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

FILE: sv/hgc_ang_conv.sv
// Degrees to 32-bit binary angle, three stages, four lanes.
module hgc_ang_conv (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  logic signed [hgc_pkg::DEG_W-1:0] i_deg [hgc_pkg::LANES],
    output logic                             o_valid,
    output logic [hgc_pkg::BANG_W-1:0]       o_bang [hgc_pkg::LANES]
);
    import hgc_pkg::*;

    localparam int SH    = BANG_W - ANGLE_FRAC_BITS;
    localparam int MAG_W = DEG_W;
    localparam int A_W   = DEG_W - 9;
    localparam int T_W   = 9 + SH;
    localparam int K1    = 38;
    localparam int M1_W  = 30;
    localparam int K2    = 40;
    localparam int M2_W  = 32;
    localparam logic [M1_W-1:0] M1 = M1_W'(((64'd1 << K1) + 64'd359) / 64'd360);
    localparam logic [M2_W-1:0] M2 = M2_W'(((64'd1 << K2) + 64'd359) / 64'd360);

    logic [2:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [MAG_W-1:0]      w_mag;
        logic [MAG_W+M1_W-1:0] w_p1;
        logic [MAG_W-1:0]      w_a360;
        logic [MAG_W-1:0]      w_diff;
        logic [T_W+M2_W-1:0]   w_p2;
        logic [BANG_W-1:0]     w_q;
        logic [MAG_W-1:0]      r_mag1;
        logic [A_W-1:0]        r_a1;
        logic                  r_neg1;
        logic [T_W-1:0]        r_t2;
        logic [A_W-1:0]        r_a2;
        logic                  r_neg2;
        logic [BANG_W-1:0]     r_bang;

        assign w_mag  = i_deg[l][DEG_W-1] ? MAG_W'(-i_deg[l]) : MAG_W'(i_deg[l]);
        assign w_p1   = (MAG_W+M1_W)'(w_mag) * (MAG_W+M1_W)'(M1);
        assign w_a360 = MAG_W'(r_a1) * MAG_W'(9'd360);
        assign w_diff = r_mag1 - w_a360;
        assign w_p2   = (T_W+M2_W)'(r_t2) * (T_W+M2_W)'(M2);
        assign w_q    = BANG_W'({r_a2, w_p2[K2 +: SH]});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mag1 <= w_mag;
                r_a1   <= w_p1[K1 +: A_W];
                r_neg1 <= i_deg[l][DEG_W-1];
                r_t2   <= T_W'({w_diff[8:0], {SH{1'b0}}}) + T_W'(9'd180);
                r_a2   <= r_a1;
                r_neg2 <= r_neg1;
                r_bang <= r_neg2 ? (~w_q + 1'b1) : w_q;
            end
        end

        assign o_bang[l] = r_bang;
    end
endmodule

FILE: sv/hgc_sincos.sv
// Pipelined rotation CORDIC, sine and cosine for four angles.
module hgc_sincos (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [hgc_pkg::BANG_W-1:0]  i_ang [hgc_pkg::LANES],
    output logic                        o_valid,
    output logic signed [hgc_pkg::CW-1:0] o_sin [hgc_pkg::LANES],
    output logic signed [hgc_pkg::CW-1:0] o_cos [hgc_pkg::LANES]
);
    import hgc_pkg::*;

    localparam int ST = CORDIC_STEPS;

    logic [ST+1:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ST:0], i_valid};
        end
    end

    assign o_valid = r_v[ST+1];

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [CW-1:0] r_x [0:ST];
        logic signed [CW-1:0] r_y [0:ST];
        logic signed [CW-1:0] r_z [0:ST-1];
        logic                 r_neg [0:ST];
        logic signed [CW-1:0] r_s;
        logic signed [CW-1:0] r_c;
        logic                 w_neg;
        logic [BANG_W-1:0]    w_ang;

        assign w_neg = (i_ang[l][31:30] == 2'b01) || (i_ang[l][31:30] == 2'b10);
        assign w_ang = w_neg ? (i_ang[l] - 32'h8000_0000) : i_ang[l];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[0]   <= CORDIC_GAIN;
                r_y[0]   <= '0;
                r_z[0]   <= CW'($signed(w_ang));
                r_neg[0] <= w_neg;
                r_s      <= r_neg[ST] ? -r_y[ST] : r_y[ST];
                r_c      <= r_neg[ST] ? -r_x[ST] : r_x[ST];
            end
        end

        for (genvar s = 0; s < ST; s++) begin : g_step
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_neg[s+1] <= r_neg[s];
                    if (!r_z[s][CW-1]) begin
                        r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                        r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                    end else begin
                        r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                        r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                    end
                end
            end
            if (s < ST - 1) begin : g_z
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_z[s+1] <= r_z[s][CW-1] ? (r_z[s] + atan_c(s))
                                                  : (r_z[s] - atan_c(s));
                    end
                end
            end
        end

        assign o_sin[l] = r_s;
        assign o_cos[l] = r_c;
    end
endmodule

FILE: sv/hgc_isqrt.sv
// Pipelined bitwise integer square root of (v << 30), two lanes.
module hgc_isqrt (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [hgc_pkg::Q30_W-1:0]  i_rad [hgc_pkg::SQ_LANES],
    output logic                       o_valid,
    output logic [hgc_pkg::Q30_W-1:0]  o_root [hgc_pkg::SQ_LANES]
);
    import hgc_pkg::*;

    localparam int NW = 62;
    localparam int ST = SQRT_STEPS;

    logic [ST:0] r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ST-1:0], i_valid};
        end
    end

    assign o_valid = r_v[ST];

    for (genvar l = 0; l < SQ_LANES; l++) begin : g_lane
        logic [NW-1:0] r_n [0:ST-1];
        logic [NW-1:0] r_r [0:ST];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[0] <= NW'({i_rad[l], 30'd0});
                r_r[0] <= '0;
            end
        end

        for (genvar k = 0; k < ST; k++) begin : g_step
            localparam logic [NW-1:0] B = NW'(1) << (60 - 2 * k);
            logic [NW-1:0] w_s;
            logic          w_ge;

            assign w_s  = r_r[k] + B;
            assign w_ge = (r_n[k] >= w_s);

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_r[k+1] <= w_ge ? ((r_r[k] >> 1) + B) : (r_r[k] >> 1);
                end
            end
            if (k < ST - 1) begin : g_n
                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_n[k+1] <= w_ge ? (r_n[k] - w_s) : r_n[k];
                    end
                end
            end
        end

        assign o_root[l] = r_r[ST][Q30_W-1:0];
    end
endmodule

FILE: sv/hgc_atan.sv
// Pipelined vectoring CORDIC, first-quadrant atan2 as a clamped binary angle.
module hgc_atan (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [hgc_pkg::Q30_W-1:0] i_x,
    input  logic [hgc_pkg::Q30_W-1:0] i_y,
    output logic                      o_valid,
    output logic [hgc_pkg::Q30_W-1:0] o_z
);
    import hgc_pkg::*;

    localparam int ST = CORDIC_STEPS;

    logic [ST+1:0]        r_v;
    logic signed [CW-1:0] r_x [0:ST-1];
    logic signed [CW-1:0] r_y [0:ST-1];
    logic signed [CW-1:0] r_z [0:ST];
    logic [Q30_W-1:0]     r_zc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[ST:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= $signed(CW'(i_x));
            r_y[0] <= $signed(CW'(i_y));
            r_z[0] <= '0;
            if (r_z[ST][CW-1]) begin
                r_zc <= '0;
            end else if (r_z[ST] > $signed(CW'(ONE_Q30))) begin
                r_zc <= ONE_Q30;
            end else begin
                r_zc <= r_z[ST][Q30_W-1:0];
            end
        end
    end

    for (genvar s = 0; s < ST; s++) begin : g_step
        logic w_pos;
        assign w_pos = !r_y[s][CW-1] && (r_y[s] != '0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_z[s+1] <= w_pos ? (r_z[s] + atan_c(s)) : (r_z[s] - atan_c(s));
            end
        end
        if (s < ST - 1) begin : g_xy
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    if (w_pos) begin
                        r_x[s+1] <= r_x[s] + (r_y[s] >>> s);
                        r_y[s+1] <= r_y[s] - (r_x[s] >>> s);
                    end else begin
                        r_x[s+1] <= r_x[s] - (r_y[s] >>> s);
                        r_y[s+1] <= r_y[s] + (r_x[s] >>> s);
                    end
                end
            end
        end
    end

    assign o_valid = r_v[ST+1];
    assign o_z     = r_zc;
endmodule

FILE: sv/haversine_geofence_check.sv
// Top level: haversine distance to a reference point with geofence flag.
// Usage:
//   Input channel (i_in_valid/o_in_ready) takes one point: i_pt_lat, i_pt_lon,
//   signed degrees with 20 fractional bits. Output channel
//   (o_out_valid/i_out_ready) gives o_distance in meters with 4 fractional
//   bits and o_within_res, set when the distance is below max_dist meters.
//   APB port: ref_lat at 0x0, ref_lon at 0x4, max_dist at 0x8; write only
//   while no item is in flight.
//   Pipeline stages from acceptance to o_out_valid: 3 angle conversion,
//   1 difference, 30 sin/cos CORDIC, 3 multiply, 32 square root,
//   30 atan2 CORDIC, 1 radians scale, 1 output register.
//   Throughput is one item per cycle when not stalled. The pipeline
//   advances as one: when the output holds an item that is not taken,
//   every stage holds and o_in_ready is low; no item is lost or repeated.
//   Reset (synchronous, active low) clears all valid bits and sets
//   ref_lat = 0, ref_lon = 0, max_dist = 30.
module haversine_geofence_check (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [hgc_pkg::LAT_W-1:0]   i_pt_lat,
    input  logic signed [hgc_pkg::LON_W-1:0]   i_pt_lon,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [hgc_pkg::DIST_W-1:0]         o_distance,
    output logic                               o_within_res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import hgc_pkg::*;

    localparam int PW  = 55;
    localparam int D_W = PW - (30 - DIST_FRAC_BITS);

    logic [LAT_W-1:0]  r_ref_lat;
    logic [LON_W-1:0]  r_ref_lon;
    logic [MAXD_W-1:0] r_max_dist;
    logic              w_en;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_lat  <= '0;
            r_ref_lon  <= '0;
            r_max_dist <= MAX_DIST_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_REF_LAT:  r_ref_lat  <= pwdata[LAT_W-1:0];
                REG_REF_LON:  r_ref_lon  <= pwdata[LON_W-1:0];
                REG_MAX_DIST: r_max_dist <= pwdata[MAXD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_REF_LAT:  prdata = 32'(r_ref_lat);
            REG_REF_LON:  prdata = 32'(r_ref_lon);
            REG_MAX_DIST: prdata = 32'(r_max_dist);
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    logic r_out_v;
    assign w_en       = !r_out_v || i_out_ready;
    assign o_in_ready = w_en;

    // angle conversion: ref_lat, pt_lat, ref_lon, pt_lon
    logic signed [DEG_W-1:0] w_deg [LANES];
    logic [BANG_W-1:0]       w_bang [LANES];
    logic                    w_cv_v;

    assign w_deg[0] = DEG_W'($signed(r_ref_lat));
    assign w_deg[1] = DEG_W'(i_pt_lat);
    assign w_deg[2] = DEG_W'($signed(r_ref_lon));
    assign w_deg[3] = DEG_W'(i_pt_lon);

    hgc_ang_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in_valid),
        .i_deg   (w_deg),
        .o_valid (w_cv_v),
        .o_bang  (w_bang)
    );

    // half differences and the two latitudes
    logic [BANG_W-1:0] r_h [LANES];
    logic              r_h_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_v <= 1'b0;
        end else if (w_en) begin
            r_h_v <= w_cv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h[0] <= (w_bang[1] - w_bang[0]) >> 1;
            r_h[1] <= (w_bang[3] - w_bang[2]) >> 1;
            r_h[2] <= w_bang[0];
            r_h[3] <= w_bang[1];
        end
    end

    logic signed [CW-1:0] w_sin [LANES];
    logic signed [CW-1:0] w_cos [LANES];
    logic                 w_sc_v;

    hgc_sincos u_sincos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_h_v),
        .i_ang   (r_h),
        .o_valid (w_sc_v),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    // haversine term
    logic signed [2*CW-1:0] w_pa;
    logic signed [2*CW-1:0] w_pb;
    logic signed [2*CW-1:0] w_pc;
    logic signed [2*HW-1:0] w_pd;
    logic signed [HW:0]     w_sum;
    logic signed [HW-1:0]   r_hav1;
    logic signed [HW-1:0]   r_hav2;
    logic signed [HW-1:0]   r_cc;
    logic signed [HW-1:0]   r_hav1b;
    logic signed [HW-1:0]   r_prod;
    logic [Q30_W-1:0]       r_a;
    logic [2:0]             r_m_v;

    assign w_pa  = w_sin[0] * w_sin[0];
    assign w_pb  = w_sin[1] * w_sin[1];
    assign w_pc  = w_cos[2] * w_cos[3];
    assign w_pd  = r_cc * r_hav2;
    assign w_sum = (HW+1)'(r_hav1b) + (HW+1)'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= '0;
        end else if (w_en) begin
            r_m_v <= {r_m_v[1:0], w_sc_v};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hav1  <= w_pa[30 +: HW];
            r_hav2  <= w_pb[30 +: HW];
            r_cc    <= w_pc[30 +: HW];
            r_hav1b <= r_hav1;
            r_prod  <= w_pd[30 +: HW];
            if (w_sum[HW]) begin
                r_a <= '0;
            end else if (w_sum > $signed((HW+1)'(ONE_Q30))) begin
                r_a <= ONE_Q30;
            end else begin
                r_a <= w_sum[Q30_W-1:0];
            end
        end
    end

    // roots: lane 0 sqrt(a), lane 1 sqrt(1 - a)
    logic [Q30_W-1:0] w_rad [SQ_LANES];
    logic [Q30_W-1:0] w_root [SQ_LANES];
    logic             w_sq_v;

    assign w_rad[0] = r_a;
    assign w_rad[1] = ONE_Q30 - r_a;

    hgc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_m_v[2]),
        .i_rad   (w_rad),
        .o_valid (w_sq_v),
        .o_root  (w_root)
    );

    logic [Q30_W-1:0] w_z;
    logic             w_at_v;

    hgc_atan u_atan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sq_v),
        .i_x     (w_root[1]),
        .i_y     (w_root[0]),
        .o_valid (w_at_v),
        .o_z     (w_z)
    );

    // central angle in radians, then meters
    logic [Q30_W+31:0] w_tp;
    logic [PW-1:0]     w_dp;
    logic [D_W-1:0]    w_d;
    logic [31:0]       r_theta;
    logic              r_t_v;
    logic [DIST_W-1:0] r_dist;
    logic              r_within;

    assign w_tp = (Q30_W+32)'(w_z) * (Q30_W+32)'(PI_Q29);
    assign w_dp = PW'(r_theta) * PW'(EARTH_R);
    assign w_d  = w_dp[PW-1 : 30-DIST_FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_t_v   <= w_at_v;
            r_out_v <= r_t_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_theta  <= w_tp[29 +: 32];
            r_dist   <= (64'(w_d) > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(w_d);
            r_within <= 64'(w_d) < (64'(r_max_dist) << DIST_FRAC_BITS);
        end
    end

    assign o_out_valid  = r_out_v;
    assign o_distance   = r_dist;
    assign o_within_res = r_within;

    a_hav_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sq_v |-> (w_root[0] <= ONE_Q30) && (w_root[1] <= ONE_Q30))
        else $error("square root above one");

    a_theta_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_t_v |-> (33'(r_theta) <= (33'(PI_Q29) << 1)))
        else $error("central angle above pi");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_theta) && $stable(r_t_v) && $stable(r_a))
        else $error("pipeline moved during stall");
endmodule

FILE: dv/tb_haversine_geofence_check.sv
// Testbench for haversine_geofence_check: random and directed points against a distance predictor.
module tb_haversine_geofence_check;
    timeunit 1ns;
    timeprecision 1ps;
    import hgc_pkg::*;

    localparam int LATENCY = 101;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 1850;
    localparam logic signed [63:0] LAT_MAX = 64'sd94371840;
    localparam logic signed [63:0] LON_MAX = 64'sd188743680;

    typedef struct packed {
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } t_point;

    typedef struct packed {
        logic [DIST_W-1:0] meters;
        logic              in_fence;
    } t_fence_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic signed [LAT_W-1:0] i_pt_lat = '0;
    logic signed [LON_W-1:0] i_pt_lon = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [DIST_W-1:0] o_distance;
    logic o_within_res;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    haversine_geofence_check dut (.*);

    always #6 i_clk = ~i_clk;

    // configuration mirror
    logic signed [LAT_W-1:0] cfg_lat = '0;
    logic signed [LON_W-1:0] cfg_lon = '0;
    logic [MAXD_W-1:0] cfg_maxd = MAX_DIST_RST;

    t_point pending_pts[$];
    t_fence_res expected_fence[$];
    int n_sent = 0, n_recv = 0, n_errors = 0, n_mismatch = 0;
    int idle_cycles = 0;
    bit hold_rx = 0;
    int in_gap = 0, out_gap = 0;
    int n_cfg = 0;

    function automatic logic signed [63:0] asr64(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic [31:0] deg_to_angle(logic signed [63:0] v);
        logic [63:0] mag, q;
        mag = (v < 0) ? -v : v;
        q = (mag * (64'd1 << (32 - ANGLE_FRAC_BITS)) + 64'd180) / 64'd360;
        if (v < 0) q = 64'd0 - q;
        return q[31:0];
    endfunction

    function automatic logic signed [63:0] atan_step(int i);
        return 64'(atan_c(i));
    endfunction

    function automatic void rot_sincos(input logic [31:0] ang,
                                       output logic signed [63:0] s,
                                       output logic signed [63:0] c);
        logic neg;
        logic signed [63:0] x, y, z, dx, dy;
        neg = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (neg) ang = ang - 32'h8000_0000;
        z = 64'($signed(ang));
        x = 64'(CORDIC_GAIN);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = asr64(y, i);
            dy = asr64(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endfunction

    function automatic logic signed [63:0] vec_atan2(logic signed [63:0] x,
                                                     logic signed [63:0] y);
        logic signed [63:0] z, dx, dy;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = asr64(y, i);
            dy = asr64(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        if (z < 0) z = 0;
        if (z > 64'sd1073741824) z = 64'sd1073741824;
        return z;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 60;
        for (int k = 0; k < 31; k++) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_fence_res predict_fence(t_point p);
        logic [31:0] p1, l1, p2, l2;
        logic signed [63:0] s1, s2, c1, c2, t, hav1, hav2, cc, a, z;
        logic [63:0] ry, rx, theta, d;
        t_fence_res r;
        p1 = deg_to_angle(64'(cfg_lat));
        l1 = deg_to_angle(64'(cfg_lon));
        p2 = deg_to_angle(64'(p.lat));
        l2 = deg_to_angle(64'(p.lon));
        rot_sincos((p2 - p1) >> 1, s1, t);
        rot_sincos((l2 - l1) >> 1, s2, t);
        rot_sincos(p1, t, c1);
        rot_sincos(p2, t, c2);
        hav1 = asr64(s1 * s1, 30);
        hav2 = asr64(s2 * s2, 30);
        cc = asr64(c1 * c2, 30);
        a = hav1 + asr64(cc * hav2, 30);
        if (a < 0) a = 0;
        if (a > 64'sd1073741824) a = 64'sd1073741824;
        ry = int_sqrt(64'(a) << 30);
        rx = int_sqrt((64'd1073741824 - 64'(a)) << 30);
        z = vec_atan2($signed(rx), $signed(ry));
        theta = (64'(z) * 64'd2 * 64'(PI_Q29)) >> 30;
        d = ((theta * 64'(EARTH_R)) << DIST_FRAC_BITS) >> 30;
        r.in_fence = d < (64'(cfg_maxd) << DIST_FRAC_BITS);
        r.meters = (d > 64'(DIST_MAX)) ? DIST_MAX : d[DIST_W-1:0];
        return r;
    endfunction

    // accept flags as sampled at the previous rising edge
    logic o_in_ready_s = 1'b0;
    always @(posedge i_clk) begin
        o_in_ready_s <= 1'b0;
        if (i_in_valid && o_in_ready) begin
            expected_fence.insert(expected_fence.size(),
                                  predict_fence({i_pt_lat, i_pt_lon}));
            n_sent++;
            o_in_ready_s <= 1'b1;
        end
    end

    // driver
    t_point cur_pt;
    always @(negedge i_clk) begin
        if (i_rst_n && !(i_in_valid && !o_in_ready_s)) begin
            if (i_in_valid) in_gap = $urandom_range(0, 9);
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_pts.size() > 0) begin
                cur_pt = pending_pts.pop_front();
                i_pt_lat <= cur_pt.lat;
                i_pt_lon <= cur_pt.lon;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver ready
    always @(negedge i_clk) begin
        if (hold_rx) begin
            i_out_ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // monitor
    t_fence_res exp_r;
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            n_recv++;
            out_gap = $urandom_range(0, 9);
            if ($urandom_range(0, 3) == 0) out_gap = 0;
            if (expected_fence.size() == 0) begin
                n_errors++;
                if (n_mismatch++ < 10) $display("unexpected item: dist %0d", o_distance);
            end else begin
                exp_r = expected_fence.pop_front();
                if (exp_r.meters !== o_distance || exp_r.in_fence !== o_within_res) begin
                    n_errors++;
                    if (n_mismatch++ < 10)
                        $display("mismatch: dist exp %0d got %0d, within exp %0b got %0b",
                                 exp_r.meters, o_distance, exp_r.in_fence, o_within_res);
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || hold_rx ||
            (pending_pts.size() == 0 && expected_fence.size() == 0 && !i_in_valid))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_REF_LAT:  cfg_lat = val[LAT_W-1:0];
            REG_REF_LON:  cfg_lon = val[LON_W-1:0];
            REG_MAX_DIST: cfg_maxd = val[MAXD_W-1:0];
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic drain();
        while (pending_pts.size() > 0 || i_in_valid || expected_fence.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    function automatic logic signed [63:0] rand_span(logic signed [63:0] lim);
        return $signed(64'($urandom_range(0, 32'(2 * lim)))) - lim;
    endfunction

    function automatic t_point near_pt(int spread);
        t_point p;
        p.lat = cfg_lat + LAT_W'($signed(32'($urandom_range(0, 2 * spread)) - spread));
        p.lon = cfg_lon + LON_W'($signed(32'($urandom_range(0, 2 * spread)) - spread));
        return p;
    endfunction

    function automatic t_point rand_pt();
        t_point p;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
            p = near_pt(32'($urandom_range(1, 400)));
        end else if (sel < 8) begin
            p.lat = LAT_W'(rand_span(LAT_MAX));
            p.lon = LON_W'(rand_span(LON_MAX));
        end else begin
            p.lat = LAT_W'($urandom);
            p.lon = LON_W'($urandom);
        end
        return p;
    endfunction

    task automatic push_pt(logic signed [63:0] la, logic signed [63:0] lo);
        pending_pts.insert(pending_pts.size(), {LAT_W'(la), LON_W'(lo)});
    endtask

    initial begin
        int phase_items;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, antipodes, exact radius edges, raw bit patterns
        push_pt(0, 0);
        push_pt(LAT_MAX, 0);
        push_pt(-LAT_MAX, 0);
        push_pt(0, LON_MAX);
        push_pt(0, -LON_MAX);
        push_pt(LAT_MAX, LON_MAX);
        push_pt(-LAT_MAX, -LON_MAX);
        push_pt(1, 1);
        push_pt(-1, -1);
        push_pt(270, 0);
        push_pt(0, 300);
        push_pt(64'sh7FF_FFFF, 64'shFFF_FFFF);
        push_pt(-64'sh800_0000, -64'sh1000_0000);
        push_pt(-1, 64'shFFF_FFFF);
        push_pt(64'sh555_5555, 64'shAAA_AAAA);
        drain();

        apb_write(REG_REF_LAT, 32'(LAT_MAX));
        apb_write(REG_REF_LON, 32'(-LON_MAX));
        apb_write(REG_MAX_DIST, 32'hFFFF);
        push_pt(-LAT_MAX, LON_MAX);
        push_pt(LAT_MAX, -LON_MAX);
        push_pt(LAT_MAX - 400, -LON_MAX + 10);
        push_pt(-LAT_MAX, 0);
        drain();

        apb_write(REG_MAX_DIST, 32'h0);
        push_pt(LAT_MAX, -LON_MAX);
        push_pt(0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    apb_write(REG_REF_LAT, 32'(-LAT_MAX));
                    apb_write(REG_REF_LON, 32'(LON_MAX));
                    apb_write(REG_MAX_DIST, 30);
                end
                1: begin
                    apb_write(REG_REF_LAT, 0);
                    apb_write(REG_REF_LON, 0);
                    apb_write(REG_MAX_DIST, 1);
                end
                default: begin
                    apb_write(REG_REF_LAT, 32'(rand_span(LAT_MAX)));
                    apb_write(REG_REF_LON, 32'(rand_span(LON_MAX)));
                    apb_write(REG_MAX_DIST, $urandom_range(0, 65535));
                end
            endcase
            phase_items = N_RANDOM / 6;
            if (ph == 2) begin
                // long receiver stall while the sender keeps offering
                hold_rx = 1;
                for (int k = 0; k < phase_items; k++)
                    pending_pts.insert(pending_pts.size(), rand_pt());
                repeat (400) @(posedge i_clk);
                hold_rx = 0;
            end else begin
                for (int k = 0; k < phase_items; k++)
                    pending_pts.insert(pending_pts.size(), rand_pt());
            end
            drain();
        end

        $display("covered %0d items, %0d results, %0d register writes, stall and drain phases",
                 n_sent, n_recv, n_cfg);
        if (n_errors == 0 && expected_fence.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
